// ===== hw/rtl/smm_pkg.sv =====
`default_nettype none

package smm_pkg;

  // Store dimension; rows and columns of both operand stores.
  localparam int MAX_N = 32;

  localparam int IDX_W  = $clog2(MAX_N);      // store row/column index
  localparam int ADDR_W = 2 * IDX_W;          // store address {row, col}
  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int K_W    = $clog2(MAX_N + 1);  // holds 0..MAX_N

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int POS_W    = 5;
  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int ACC_W    = 48;
  localparam int N_SIZE_W = 6;

  localparam logic [N_SIZE_W-1:0] N_SIZE_RST = N_SIZE_W'(32);

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [ELEM_W-1:0]   elem_t;
  typedef logic [ACC_W-1:0]    acc_t;
  typedef logic [N_SIZE_W-1:0] n_size_t;

  localparam op_t OP_WRITE_A = 2'd0;
  localparam op_t OP_WRITE_B = 2'd1;
  localparam op_t OP_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smm_if.sv =====
`default_nettype none

interface smm_in_if;
  import smm_pkg::*;
  logic  valid;
  logic  ready;
  op_t   op;
  pos_t  row;
  pos_t  col;
  elem_t value;
  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface smm_out_if;
  import smm_pkg::*;
  logic valid;
  logic ready;
  acc_t c_value;
  logic in_range;
  modport source (output valid, c_value, in_range, input ready);
  modport sink   (input valid, c_value, in_range, output ready);
endinterface

interface smm_cfg_if;
  import smm_pkg::*;
  logic    valid;
  logic    ready;
  n_size_t n_size;
  modport source (output valid, n_size, input ready);
  modport sink   (input valid, n_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smm_ram.sv =====
`default_nettype none

module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/square_matrix_multiply.sv =====
`default_nettype none

// Square matrix multiply engine, signed Q8.8 elements, Q32.16 results.
// Channels (valid/ready, a transaction moves on a clock edge with both high):
//   in_item  : op, row, col, value. WRITE_A / WRITE_B store value at (row, col);
//              writes outside the store are dropped. COMPUTE asks
//              for C[row][col] = sum over k < n of A[row][k] * B[k][col].
//   out_item : c_value, in_range. One result per COMPUTE, none for writes.
//   cfg      : n_size, the active dimension (values above MAX_N act as MAX_N).
//              Write only while idle; always ready.
// A single multiply-accumulate unit walks k, one term per cycle: operand
// reads from the two block RAMs, a registered 16x16 product, then the 48-bit
// add. A COMPUTE in range passes through RUN and DRAIN to DONE, which loads
// the result register; out of range it goes straight to DONE and returns
// zero with in_range 0. in_item is not ready while a COMPUTE is in flight;
// a write is taken every cycle. The result sits in an output register, so
// the next transaction is accepted while it waits; a finished COMPUTE holds
// in DONE only if the previous result is still stalled. Reset sets n_size
// to 32 and empties the pipeline; the operand stores keep no reset value.
module square_matrix_multiply (
  input wire logic  clk,
  input wire logic  rst,
  smm_in_if.sink    in_item,
  smm_out_if.source out_item,
  smm_cfg_if.sink   cfg
);
  import smm_pkg::*;

  state_t  state, state_next;
  n_size_t n_size;
  logic [K_W-1:0] n_act;
  logic [K_W-1:0] k;
  pos_t    row_r, col_r;
  logic    ok_r;

  logic    in_acc, cmp_ok, in_store;
  logic    we_a, we_b, rd_en, load_out, k_last;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
  elem_t   a_rdata, b_rdata;

  // MAC pipeline
  logic               rd_vld, mul_vld;
  logic signed [PROD_W-1:0] prod;
  acc_t               acc;

  // Output register
  logic out_valid;
  acc_t out_c;
  logic out_rng;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_size <= N_SIZE_RST;
    end else if (cfg.valid) begin
      n_size <= cfg.n_size;
    end
  end

  // saturate to the store size
  assign n_act = (int'(n_size) > MAX_N) ? K_W'(MAX_N) : K_W'(n_size);

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  assign in_acc   = in_item.valid && in_item.ready;
  assign cmp_ok   = (int'(in_item.row) < int'(n_act)) && (int'(in_item.col) < int'(n_act));
  assign in_store = (int'(in_item.row) < MAX_N) && (int'(in_item.col) < MAX_N);
  assign we_a     = in_acc && (in_item.op == OP_WRITE_A) && in_store;
  assign we_b     = in_acc && (in_item.op == OP_WRITE_B) && in_store;
  assign waddr    = {IDX_W'(in_item.row), IDX_W'(in_item.col)};
  assign a_raddr  = {IDX_W'(row_r), IDX_W'(k)};
  assign b_raddr  = {IDX_W'(k), IDX_W'(col_r)};
  assign k_last   = (k + K_W'(1)) == n_act;

  // ---------------------------------------------------------------------
  // Operand stores
  // ---------------------------------------------------------------------
  smm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_item.value),
    .re    (rd_en),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_item.value),
    .re    (rd_en),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_item.op == OP_COMPUTE)) begin
          state_next = cmp_ok ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait until the last product has landed in acc
        if (!rd_vld && !mul_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_item.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_item.ready = 1'b0;
    rd_en         = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:  in_item.ready = 1'b1;
      ST_RUN:   rd_en         = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_out      = !out_valid || out_item.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_vld  <= 1'b0;
      mul_vld <= 1'b0;
    end else begin
      state   <= state_next;
      rd_vld  <= rd_en;
      mul_vld <= rd_vld;
    end
  end

  // Item registers and k counter
  always_ff @(posedge clk) begin
    if (in_acc && (in_item.op == OP_COMPUTE)) begin
      row_r <= in_item.row;
      col_r <= in_item.col;
      ok_r  <= cmp_ok;
      k     <= '0;
    end else if (rd_en) begin
      k <= k + K_W'(1);
    end
  end

  // Shared MAC: registered product, then accumulate
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prod <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (in_acc && (in_item.op == OP_COMPUTE)) begin
      acc <= '0;
    end else if (mul_vld) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_c   <= acc;
      out_rng <= ok_r;
    end
  end

  assign out_item.valid    = out_valid;
  assign out_item.c_value  = out_c;
  assign out_item.in_range = out_rng;

`ifndef SYNTHESIS
  a_accept_pipe_empty : assert property (@(posedge clk) disable iff (rst)
    in_acc |-> (!rd_vld && !mul_vld))
    else $error("transaction accepted while MAC pipeline busy");

  a_k_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (k < n_act))
    else $error("k counter ran past active size");

  a_out_of_range_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_rng) |-> (out_c == '0))
    else $error("out-of-range result is not zero");

  a_compute_leaves_idle : assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_item.op == OP_COMPUTE)) |=> (state != ST_IDLE))
    else $error("compute transaction did not start the sequencer");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_square_matrix_multiply.sv =====
`default_nettype none

module tb_square_matrix_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  import smm_pkg::*;

  // op code the block drops without a result
  localparam op_t OP_UNUSED = 2'd3;

  // cycles left after the last result for writes still in flight
  localparam int SETTLE_CYCLES = 40;

  // Holds the operand stores and the active size, works out each C element
  // when its compute transaction is taken, and checks results in order.
  class matmul_scoreboard;
    typedef struct packed {
      acc_t c_value;
      logic in_range;
    } c_elem_t;

    elem_t     a_store  [MAX_N][MAX_N];
    elem_t     b_store  [MAX_N][MAX_N];
    bit        a_loaded [MAX_N][MAX_N];
    bit        b_loaded [MAX_N][MAX_N];
    n_size_t   n_reg;
    c_elem_t   c_queue[$];
    int        errors;

    function new();
      n_reg  = N_SIZE_RST;
      errors = 0;
    endfunction

    // sizes above the store saturate
    function int active_n();
      if (n_reg > MAX_N) return MAX_N;
      return int'(n_reg);
    endfunction

    function void set_size(n_size_t v);
      n_reg = v;
    endfunction

    function int pending();
      return c_queue.size();
    endfunction

    function void note_item(op_t op, pos_t row, pos_t col, elem_t value);
      c_elem_t expected;
      longint  dot;
      int      n;
      n = active_n();
      case (op)
        OP_WRITE_A: begin
          if (row < MAX_N && col < MAX_N) begin
            a_store[row][col]  = value;
            a_loaded[row][col] = 1'b1;
          end
        end
        OP_WRITE_B: begin
          if (row < MAX_N && col < MAX_N) begin
            b_store[row][col]  = value;
            b_loaded[row][col] = 1'b1;
          end
        end
        OP_COMPUTE: begin
          dot = 0;
          if (row < n && col < n) begin
            for (int k = 0; k < n; k++)
              dot += longint'($signed(a_store[row][k])) * longint'($signed(b_store[k][col]));
            expected.in_range = 1'b1;
          end else begin
            expected.in_range = 1'b0;
          end
          expected.c_value = acc_t'(dot);
          c_queue.push_back(expected);
        end
        default: ;
      endcase
    endfunction

    function void check_result(acc_t c_value, logic in_range);
      c_elem_t expected;
      if (c_queue.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("C result error: result with nothing pending, c_value %h in_range %0b",
                   c_value, in_range);
        return;
      end
      expected = c_queue.pop_front();
      if (expected.c_value !== c_value || expected.in_range !== in_range) begin
        errors++;
        if (errors <= 10)
          $display("C result error: expected c_value %h in_range %0b, got c_value %h in_range %0b",
                   expected.c_value, expected.in_range, c_value, in_range);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  smm_in_if  in_bus();
  smm_out_if out_bus();
  smm_cfg_if cfg_bus();

  square_matrix_multiply u_top (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_bus),
    .out_item (out_bus),
    .cfg      (cfg_bus)
  );

  matmul_scoreboard sb;
  bit               no_idle;
  int               items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #10_000_000;
    $display("square_matrix_multiply: mismatch");
    $finish;
  end

  // result side: random stall before each result transaction
  initial begin : result_sink
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      repeat (stall) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && !rst));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.c_value, out_bus.in_range);
  end

  function automatic elem_t pick_value();
    case ($urandom_range(0, 19))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return elem_t'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic pos_t pick_pos();
    return pos_t'($urandom_range(0, MAX_N - 1));
  endfunction

  task automatic send_item(op_t op, pos_t row, pos_t col, elem_t value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.op    <= op;
    in_bus.row   <= row;
    in_bus.col   <= col;
    in_bus.value <= value;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_item(op, row, col, value);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // drop valid, then hold off until every C result is back
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_size(n_size_t v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid  <= 1'b1;
    cfg_bus.n_size <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_size(v);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // load whatever of A row / B column is still unwritten, then compute
  task automatic compute_in_range(pos_t row, pos_t col);
    int n;
    n = sb.active_n();
    for (int k = 0; k < n; k++) begin
      if (!sb.a_loaded[row][k]) send_item(OP_WRITE_A, row, pos_t'(k), pick_value());
      if (!sb.b_loaded[k][col]) send_item(OP_WRITE_B, pos_t'(k), col, pick_value());
    end
    send_item(OP_COMPUTE, row, col, pick_value());
  endtask

  task automatic run_phase(int phase);
    int   n;
    int   ops;
    int   r;
    pos_t row;
    pos_t col;
    op_t  op;
    n   = sb.active_n();
    ops = (n > 12) ? $urandom_range(4, 10) : $urandom_range(15, 40);
    for (int i = 0; i < ops; i++) begin
      if (i == ops / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
        wait_drained();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(OP_UNUSED, pick_pos(), pick_pos(), pick_value());
      end else if (r < 18) begin
        // compute outside the active size
        if (n < MAX_N) begin
          row = pick_pos();
          col = pick_pos();
          if ($urandom_range(0, 1) != 0) row = pos_t'($urandom_range(n, MAX_N - 1));
          else                           col = pos_t'($urandom_range(n, MAX_N - 1));
          send_item(OP_COMPUTE, row, col, pick_value());
        end else begin
          send_item(OP_UNUSED, pick_pos(), pick_pos(), pick_value());
        end
      end else if (r < 45) begin
        op = ($urandom_range(0, 1) != 0) ? OP_WRITE_B : OP_WRITE_A;
        if (n > 0 && $urandom_range(0, 3) != 0) begin
          row = pos_t'($urandom_range(0, n - 1));
          col = pos_t'($urandom_range(0, n - 1));
        end else begin
          row = pick_pos();
          col = pick_pos();
        end
        send_item(op, row, col, pick_value());
      end else begin
        if (n == 0)
          send_item(OP_COMPUTE, pick_pos(), pick_pos(), pick_value());
        else
          compute_in_range(pos_t'($urandom_range(0, n - 1)), pos_t'($urandom_range(0, n - 1)));
      end
    end
  endtask

  function automatic n_size_t pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return n_size_t'($urandom_range(1, 4));
    if (r < 82) return n_size_t'($urandom_range(5, 12));
    if (r < 88) return n_size_t'(32);
    if (r < 92) return n_size_t'($urandom_range(33, 63));
    if (r < 95) return n_size_t'(0);
    return n_size_t'($urandom_range(13, 31));
  endfunction

  initial begin : stimulus
    int phase;
    sb             = new();
    no_idle        = 1'b0;
    items_sent     = 0;
    rst            = 1'b1;
    in_bus.valid   = 1'b0;
    in_bus.op      = OP_WRITE_A;
    in_bus.row     = '0;
    in_bus.col     = '0;
    in_bus.value   = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.n_size = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 2x2 with full-scale operands
    write_size(n_size_t'(2));
    send_item(OP_WRITE_A, 5'd0, 5'd0, 16'h7fff);
    send_item(OP_WRITE_A, 5'd0, 5'd1, 16'h8000);
    send_item(OP_WRITE_A, 5'd1, 5'd0, 16'hffff);
    send_item(OP_WRITE_A, 5'd1, 5'd1, 16'h0001);
    send_item(OP_WRITE_B, 5'd0, 5'd0, 16'h7fff);
    send_item(OP_WRITE_B, 5'd1, 5'd0, 16'h8000);
    send_item(OP_WRITE_B, 5'd0, 5'd1, 16'h8000);
    send_item(OP_WRITE_B, 5'd1, 5'd1, 16'h8000);
    send_item(OP_COMPUTE, 5'd0, 5'd0, 16'h0000);
    send_item(OP_COMPUTE, 5'd0, 5'd1, 16'hffff);
    send_item(OP_COMPUTE, 5'd1, 5'd0, 16'h0000);
    send_item(OP_COMPUTE, 5'd1, 5'd1, 16'h0000);
    // outside the active size
    send_item(OP_COMPUTE, 5'd2, 5'd0, 16'h0000);
    send_item(OP_COMPUTE, 5'd0, 5'd31, 16'h0000);
    send_item(OP_COMPUTE, 5'd31, 5'd5, 16'h0000);
    // unused op, and writes beyond n but inside the store
    send_item(OP_UNUSED, 5'd31, 5'd31, 16'hffff);
    send_item(OP_WRITE_A, 5'd31, 5'd31, 16'h8000);
    send_item(OP_WRITE_B, 5'd30, 5'd2, 16'h7fff);
    // zero size: everything out of range
    write_size(n_size_t'(0));
    send_item(OP_COMPUTE, 5'd0, 5'd0, 16'h0000);
    send_item(OP_COMPUTE, 5'd31, 5'd31, 16'h0000);
    write_size(n_size_t'(1));
    send_item(OP_COMPUTE, 5'd0, 5'd0, 16'h0000);
    send_item(OP_COMPUTE, 5'd0, 5'd1, 16'h0000);
    send_item(OP_COMPUTE, 5'd1, 5'd0, 16'h0000);

    // random phases; the first one at the top size code (saturates)
    phase = 0;
    while (items_sent < 600) begin
      write_size(phase == 0 ? n_size_t'(63) : pick_size());
      no_idle = ($urandom_range(0, 3) == 0);
      run_phase(phase);
      phase++;
    end

    wait_drained();
    no_idle = 1'b0;
    repeat (SETTLE_CYCLES + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("square_matrix_multiply: match");
    end else begin
      $display("square_matrix_multiply: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
